@@ design/isl_pkg.sv @@
// isl_pkg: shared widths, command and status codes, cell op type and
// readout tree sizing functions for the indexed sequential list.
// No dependencies.
package isl_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 10;
  localparam int VAL_W = 16;
  localparam int ST_W  = 2;
  localparam int CNT_W = 10;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam cmd_t CMD_INS_FRONT = 3'd0;
  localparam cmd_t CMD_INS_BACK  = 3'd1;
  localparam cmd_t CMD_INS_AT    = 3'd2;
  localparam cmd_t CMD_REM_FRONT = 3'd3;
  localparam cmd_t CMD_REM_BACK  = 3'd4;
  localparam cmd_t CMD_REM_AT    = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2
  } op_t;

  // readout tree: radix 8 per registered level
  localparam int TREE_RADIX = 8;
  localparam int TREE_RLOG  = 3;

  // node count of level k for n leaves (k = -1 gives n)
  function automatic int tree_nodes(int n, int k);
    int m;
    m = n;
    for (int i = 0; i <= k; i++) begin
      m = (m + TREE_RADIX - 1) >> TREE_RLOG;
    end
    return m;
  endfunction

  function automatic int tree_levels(int n);
    int m;
    int l;
    m = (n + TREE_RADIX - 1) >> TREE_RLOG;
    l = 1;
    while (m > 1) begin
      m = (m + TREE_RADIX - 1) >> TREE_RLOG;
      l++;
    end
    return l;
  endfunction

  // first flat index of level k
  function automatic int tree_off(int n, int k);
    int s;
    s = 0;
    for (int i = 0; i < k; i++) begin
      s += tree_nodes(n, i);
    end
    return s;
  endfunction

endpackage

@@ design/isl_if.sv @@
// isl_in_if / isl_out_if: valid/ready channels for command beats and
// result beats. Depends on isl_pkg.
interface isl_in_if;
  import isl_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] item_value;

  modport source (output valid, output command, output position, output item_value,
                  input ready);
  modport sink   (input valid, input command, input position, input item_value,
                  output ready);
endinterface

interface isl_out_if;
  import isl_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] removed_value;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output removed_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input entry_count,
                  output ready);
endinterface

@@ design/isl_cell.sv @@
// isl_cell: one list slot. Takes its left neighbor on insert, its right
// neighbor on remove, and taps its value out when it is the removed slot.
// Depends on isl_pkg.
module isl_cell #(
  parameter int IDX    = 0,
  parameter int AW     = 9,
  parameter int DATA_W = 16
) (
  input  logic               clk,
  input  isl_pkg::op_t       op,
  input  logic [AW-1:0]      at,
  input  logic [DATA_W-1:0]  ins_val,
  input  logic [DATA_W-1:0]  left_q,
  input  logic [DATA_W-1:0]  right_q,
  output logic [DATA_W-1:0]  q,
  output logic [DATA_W-1:0]  tap
);
  import isl_pkg::*;

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (op)
      OP_INS: begin
        if (MY_IDX == at) begin
          q_nxt = ins_val;
        end else if (MY_IDX > at) begin
          q_nxt = left_q;
        end
      end
      OP_REM: begin
        if (MY_IDX >= at) begin
          q_nxt = right_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q   = q_r;
  assign tap = (op == OP_REM && at == MY_IDX) ? q_r : '0;

endmodule

@@ design/isl_or_tree.sv @@
// isl_or_tree: registered radix-8 OR tree that collects the one tapped
// cell value into a single word; one level per enabled cycle.
// Depends on isl_pkg.
module isl_or_tree #(
  parameter int N_IN = 512,
  parameter int W    = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] leaf [N_IN],
  output logic [W-1:0] root
);
  import isl_pkg::*;

  localparam int LEVELS = tree_levels(N_IN);
  localparam int TOTAL  = tree_off(N_IN, LEVELS);

  logic [W-1:0] node_r [TOTAL];

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    localparam int NODES   = tree_nodes(N_IN, k);
    localparam int OFF     = tree_off(N_IN, k);
    localparam int SRC_N   = tree_nodes(N_IN, k - 1);
    localparam int SRC_OFF = (k > 0) ? tree_off(N_IN, k - 1) : 0;
    for (genvar j = 0; j < NODES; j++) begin : g_node
      logic [W-1:0] acc;
      if (k == 0) begin : g_leaf
        always_comb begin
          acc = '0;
          for (int c = 0; c < TREE_RADIX; c++) begin
            if (j * TREE_RADIX + c < SRC_N) begin
              acc = acc | leaf[j * TREE_RADIX + c];
            end
          end
        end
      end else begin : g_inner
        always_comb begin
          acc = '0;
          for (int c = 0; c < TREE_RADIX; c++) begin
            if (j * TREE_RADIX + c < SRC_N) begin
              acc = acc | node_r[SRC_OFF + j * TREE_RADIX + c];
            end
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          node_r[OFF + j] <= acc;
        end
      end
    end
  end

  assign root = node_r[TOTAL-1];

endmodule

@@ design/indexed_sequential_list.sv @@
// indexed_sequential_list: top level. Command decode, count, FSM, row of
// isl_cell slots, isl_or_tree readout and output register.
// Depends on isl_pkg, isl_if, isl_cell, isl_or_tree.
//
//   channel | dir | beat contents
//   in_ch   | in  | command, position, item_value
//   out_ch  | out | removed_value, status, entry_count
//
// One command is taken at a time, in the steps accept/decode, shift and the
// L = ceil(log8(DEPTH)) levels of the removal readout tree.
// All cells shift together, in S_EXEC.
// rst_n clears count, FSM and output valid; slot contents are not cleared.
// A result waiting on out_ch does not block the next command beat; a second
// result waits in the tree until out_ch takes the first.
module indexed_sequential_list #(
  parameter int DEPTH  = 512,
  parameter int DATA_W = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  isl_in_if.sink     in_ch,
  isl_out_if.source  out_ch
);
  import isl_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int MW     = (CW > POS_W) ? CW : POS_W;
  localparam int LEVELS = tree_levels(DEPTH);
  localparam int TW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_TREE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, cnt_nxt;
  op_t                 op_r, dec_op;
  logic [AW-1:0]       at_r;
  status_t             st_r, dec_st;
  logic [CNT_W-1:0]    rcnt_r;
  logic [DATA_W-1:0]   val_r;
  logic [TW-1:0]       t_r;
  logic                out_valid_r;
  logic [VAL_W-1:0]    out_val_r;
  status_t             out_st_r;
  logic [CNT_W-1:0]    out_cnt_r;

  logic [MW-1:0]       pos_x, cnt_x, tgt;
  logic                in_fire, out_load, tree_en;
  op_t                 cell_op;
  logic [DATA_W-1:0]   q   [DEPTH];
  logic [DATA_W-1:0]   tap [DEPTH];
  logic [DATA_W-1:0]   root;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign pos_x   = MW'(in_ch.position);
  assign cnt_x   = MW'(count_r);

  always_comb begin
    dec_op  = OP_NONE;
    dec_st  = ST_OK;
    tgt     = '0;
    cnt_nxt = count_r;
    case (in_ch.command)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        if (count_r == CW'(DEPTH)) begin
          dec_st = ST_FULL;
        end else begin
          if (in_ch.command == CMD_INS_FRONT) tgt = '0;
          else if (in_ch.command == CMD_INS_BACK) tgt = cnt_x;
          else tgt = pos_x;
          if (tgt > cnt_x) begin
            dec_st = ST_RANGE;
          end else begin
            dec_op  = OP_INS;
            cnt_nxt = count_r + 1'b1;
          end
        end
      end
      CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_AT: begin
        if (count_r == '0) begin
          dec_st = ST_EMPTY;
        end else begin
          if (in_ch.command == CMD_REM_FRONT) tgt = '0;
          else if (in_ch.command == CMD_REM_BACK) tgt = cnt_x - 1'b1;
          else tgt = pos_x;
          if (tgt >= cnt_x) begin
            dec_st = ST_RANGE;
          end else begin
            dec_op  = OP_REM;
            cnt_nxt = count_r - 1'b1;
          end
        end
      end
      default: dec_op = OP_NONE;
    endcase
  end

  assign out_load = (state_r == S_TREE) && (t_r == '0) && (!out_valid_r || out_ch.ready);
  assign tree_en  = (state_r == S_EXEC) || ((state_r == S_TREE) && (t_r != '0));
  assign cell_op  = (state_r == S_EXEC) ? op_r : OP_NONE;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_TREE;
      S_TREE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      op_r        <= OP_NONE;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        count_r <= cnt_nxt;
        op_r    <= dec_op;
      end
      if (state_r == S_EXEC) begin
        t_r <= TW'(LEVELS - 1);
      end else if (tree_en) begin
        t_r <= t_r - 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      at_r   <= AW'(tgt);
      st_r   <= dec_st;
      rcnt_r <= CNT_W'(cnt_nxt);
      val_r  <= DATA_W'(in_ch.item_value);
    end
    if (out_load) begin
      out_val_r <= VAL_W'(root);
      out_st_r  <= st_r;
      out_cnt_r <= rcnt_r;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_q;
    logic [DATA_W-1:0] right_q;
    if (i == 0) begin : g_first
      assign left_q = val_r;
    end else begin : g_left
      assign left_q = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_q = q[i];
    end else begin : g_right
      assign right_q = q[i+1];
    end
    isl_cell #(
      .IDX    (i),
      .AW     (AW),
      .DATA_W (DATA_W)
    ) u_cell (
      .clk     (clk),
      .op      (cell_op),
      .at      (at_r),
      .ins_val (val_r),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (q[i]),
      .tap     (tap[i])
    );
  end

  isl_or_tree #(
    .N_IN (DEPTH),
    .W    (DATA_W)
  ) u_tree (
    .clk  (clk),
    .en   (tree_en),
    .leaf (tap),
    .root (root)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_val_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.entry_count   = out_cnt_r;

  a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EXEC)
    else $error("accepted beat did not start a shift");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(count_r))
    else $error("count changed without a command beat");

  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.removed_value != '0) |-> out_ch.status == ST_OK)
    else $error("removed handle reported on a failed command");

endmodule
